@@ design/evt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election vote tally package
// Shared sizes, operation codes and flag positions of the vote tally block.
// ----------------------------------------------------------------------------
package evt_pkg;

   localparam int MAX_PEERS = 16;
   localparam int SLOT_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W = $clog2(MAX_PEERS + 1);
   localparam int ID_W = 64;
   localparam int FUNC_W = 3;
   localparam int FLAGS_W = 4;
   localparam int TOTAL_W = 5;

   // flag bit positions
   localparam int FLAG_GRANT = 0;
   localparam int FLAG_DONE = 1;
   localparam int FLAG_LOGOK = 2;
   localparam int FLAG_IVOK = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_EMPTY = 3'd0,
      FUNC_ADD   = 3'd1,
      FUNC_CLEAR = 3'd2,
      FUNC_GRANT = 3'd3,
      FUNC_DONE  = 3'd4,
      FUNC_LOGOK = 3'd5,
      FUNC_IVOK  = 3'd6,
      FUNC_QUERY = 3'd7
   } func_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic              start;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_idx;
      logic              update;
      logic              load_out;
   } cmd_type;

endpackage

@@ design/evt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election vote tally channels
// Request and response handshake channels: valid, ready and the word.
// ----------------------------------------------------------------------------
interface evt_req_if
   import evt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   peer_id;
   logic              my_vote;

   modport source (output valid, func, peer_id, my_vote, input ready);
   modport sink (input valid, func, peer_id, my_vote, output ready);
endinterface

interface evt_rsp_if
   import evt_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               majority_grant;
   logic               majority_logok;
   logic               majority_prevote;
   logic               all_granted;
   logic [TOTAL_W-1:0] peer_total;
   logic               status;

   modport source (output valid, majority_grant, majority_logok, majority_prevote,
                   all_granted, peer_total, status, input ready);
   modport sink (input valid, majority_grant, majority_logok, majority_prevote,
                 all_granted, peer_total, status, output ready);
endinterface

@@ design/election_vote_tally.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election vote tally
// Peer table with grant, done, log-ok and interval-ok flags; one tally word
// per request word.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  req_bus   in   func, peer_id, my_vote
//  rsp_bus   out  majority_grant, majority_logok, majority_prevote,
//                 all_granted, peer_total, status
//
// Each request steps through the scan, drain, update and finish states; the scan reads
// the address memory one slot a cycle through its single read port.
// Reset empties the table at once; no clearing pass.
// A new request is taken while the previous response waits on rsp_bus;
// a stalled response holds the next one in the finish state.
// ----------------------------------------------------------------------------
module election_vote_tally
   import evt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   evt_req_if.sink      req_bus,
   evt_rsp_if.source    rsp_bus
);

   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;

   evt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   evt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_func             (req_bus.func),
      .req_peer_id          (req_bus.peer_id),
      .req_my_vote          (req_bus.my_vote),
      .rsp_majority_grant   (rsp_bus.majority_grant),
      .rsp_majority_logok   (rsp_bus.majority_logok),
      .rsp_majority_prevote (rsp_bus.majority_prevote),
      .rsp_all_granted      (rsp_bus.all_granted),
      .rsp_peer_total       (rsp_bus.peer_total),
      .rsp_status           (rsp_bus.status)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

@@ design/evt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election vote tally controller
// Sequences accept, table scan, update and result hand-off.
// ----------------------------------------------------------------------------
module evt_ctrl
   import evt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + SLOT_W'(1);
            if (idx_ff == SLOT_W'(MAX_PEERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last compare lands this cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output word slot is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/evt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election vote tally datapath
// Peer address memory, slot flags, lookup compare, tally counters, result.
// ----------------------------------------------------------------------------
module evt_datapath
   import evt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [ID_W-1:0]    req_peer_id,
   input  logic               req_my_vote,
   output logic               rsp_majority_grant,
   output logic               rsp_majority_logok,
   output logic               rsp_majority_prevote,
   output logic               rsp_all_granted,
   output logic [TOTAL_W-1:0] rsp_peer_total,
   output logic               rsp_status
);

   logic [ID_W-1:0]    addr_mem [MAX_PEERS];
   logic [ID_W-1:0]    rd_data_ff;
   logic               valid_ff [MAX_PEERS];
   logic [FLAGS_W-1:0] flags_ff [MAX_PEERS];

   func_type           func_ff;
   logic [ID_W-1:0]    id_ff;
   logic               mine_ff;

   logic               cmp_en_ff;
   logic [SLOT_W-1:0]  cmp_idx_ff;
   logic               hit_ff, free_ff;
   logic [SLOT_W-1:0]  hit_slot_ff, free_slot_ff;
   logic [FLAGS_W-1:0] hit_flags_ff;
   logic [CNT_W-1:0]   n_ff, g_ff, l_ff, p_ff;
   status_type         status_ff;

   logic               rsp_grant_ff, rsp_logok_ff, rsp_prevote_ff, rsp_all_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_status_ff;

   logic               cur_valid;
   logic [FLAGS_W-1:0] cur_flags;
   logic               is_lookup, can_place, do_place, do_insert;
   logic [SLOT_W-1:0]  sel_slot;
   logic [1:0]         flag_sel;
   logic [FLAGS_W-1:0] old_flags, new_flags;
   logic [CNT_W-1:0]   n_in, g_in, l_in, p_in;
   logic [CNT_W:0]     need, g_tot, l_tot, p_tot;

   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_flags = flags_ff[cmp_idx_ff];

   assign is_lookup = (func_ff == FUNC_ADD) || (func_ff == FUNC_GRANT) ||
                      (func_ff == FUNC_DONE) || (func_ff == FUNC_LOGOK) ||
                      (func_ff == FUNC_IVOK);
   assign can_place = hit_ff || free_ff;
   assign do_place  = cmd.update && is_lookup && can_place;
   assign do_insert = do_place && !hit_ff;
   assign sel_slot  = hit_ff ? hit_slot_ff : free_slot_ff;
   assign flag_sel  = 2'(func_ff - FUNC_GRANT);
   assign old_flags = hit_ff ? hit_flags_ff : '0;
   assign new_flags = (func_ff == FUNC_ADD) ? '0
                    : (old_flags | (FLAGS_W'(1) << flag_sel));

   // adjust scanned tallies by the one slot this item touches; empty zeroes all tallies, clear all but the peer count
   always_comb begin
      n_in = n_ff;
      g_in = g_ff;
      l_in = l_ff;
      p_in = p_ff;
      case (func_ff)
         FUNC_EMPTY: begin
            n_in = '0;
            g_in = '0;
            l_in = '0;
            p_in = '0;
         end
         FUNC_CLEAR: begin
            g_in = '0;
            l_in = '0;
            p_in = '0;
         end
         FUNC_QUERY: begin
         end
         default: begin
            if (can_place) begin
               n_in = n_ff + CNT_W'(!hit_ff);
               g_in = g_ff - CNT_W'(old_flags[FLAG_GRANT])
                           + CNT_W'(new_flags[FLAG_GRANT]);
               l_in = l_ff - CNT_W'(old_flags[FLAG_LOGOK])
                           + CNT_W'(new_flags[FLAG_LOGOK]);
               p_in = p_ff - CNT_W'(old_flags[FLAG_LOGOK] & old_flags[FLAG_IVOK])
                           + CNT_W'(new_flags[FLAG_LOGOK] & new_flags[FLAG_IVOK]);
            end
         end
      endcase
   end

   assign need  = ({1'b0, n_ff} + (CNT_W+1)'(2)) >> 1;
   assign g_tot = {1'b0, g_ff} + (CNT_W+1)'(mine_ff);
   assign l_tot = {1'b0, l_ff} + (CNT_W+1)'(mine_ff);
   assign p_tot = {1'b0, p_ff} + (CNT_W+1)'(mine_ff);

   // address memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_insert) begin
         addr_mem[sel_slot] <= id_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= addr_mem[cmd.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            valid_ff[i] <= 1'b0;
            flags_ff[i] <= '0;
         end
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.rd_en;
         if (cmd.update && (func_ff == FUNC_EMPTY)) begin
            for (int i = 0; i < MAX_PEERS; i++) begin
               valid_ff[i] <= 1'b0;
               flags_ff[i] <= '0;
            end
         end else if (cmd.update && (func_ff == FUNC_CLEAR)) begin
            for (int i = 0; i < MAX_PEERS; i++) begin
               flags_ff[i] <= '0;
            end
         end else if (do_place) begin
            valid_ff[sel_slot] <= 1'b1;
            flags_ff[sel_slot] <= new_flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmd.rd_idx;
      if (cmd.start) begin
         func_ff      <= func_type'(req_func);
         id_ff        <= req_peer_id;
         mine_ff      <= req_my_vote;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         hit_slot_ff  <= '0;
         free_slot_ff <= '0;
         hit_flags_ff <= '0;
         n_ff         <= '0;
         g_ff         <= '0;
         l_ff         <= '0;
         p_ff         <= '0;
         status_ff    <= STATUS_OK;
      end else if (cmp_en_ff) begin
         if (cur_valid) begin
            n_ff <= n_ff + CNT_W'(1);
            g_ff <= g_ff + CNT_W'(cur_flags[FLAG_GRANT]);
            l_ff <= l_ff + CNT_W'(cur_flags[FLAG_LOGOK]);
            p_ff <= p_ff + CNT_W'(cur_flags[FLAG_LOGOK] & cur_flags[FLAG_IVOK]);
            if (!hit_ff && (rd_data_ff == id_ff)) begin
               hit_ff       <= 1'b1;
               hit_slot_ff  <= cmp_idx_ff;
               hit_flags_ff <= cur_flags;
            end
         end else if (!free_ff) begin
            // lowest free slot wins
            free_ff      <= 1'b1;
            free_slot_ff <= cmp_idx_ff;
         end
      end else if (cmd.update) begin
         n_ff      <= n_in;
         g_ff      <= g_in;
         l_ff      <= l_in;
         p_ff      <= p_in;
         status_ff <= (is_lookup && !can_place) ? STATUS_FULL : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_grant_ff   <= (g_tot >= need);
         rsp_logok_ff   <= (l_tot >= need);
         rsp_prevote_ff <= (p_tot >= need);
         rsp_all_ff     <= mine_ff && (g_ff == n_ff);
         rsp_total_ff   <= TOTAL_W'(n_ff);
         rsp_status_ff  <= status_ff;
      end
   end

   assign rsp_majority_grant   = rsp_grant_ff;
   assign rsp_majority_logok   = rsp_logok_ff;
   assign rsp_majority_prevote = rsp_prevote_ff;
   assign rsp_all_granted      = rsp_all_ff;
   assign rsp_peer_total       = rsp_total_ff;
   assign rsp_status           = rsp_status_ff;

endmodule
